// ===== design/ubx_nav_pvt_frame_parser_unit_assert.svh =====
// Assertion macros used by the field emitter (ubxpvt_back) of the frame parser.
// Expects a clock i_clk and an active-low synchronous reset i_rst_n in scope.
`ifndef UBX_NAV_PVT_FRAME_PARSER_UNIT_ASSERT_SVH
`define UBX_NAV_PVT_FRAME_PARSER_UNIT_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define UBXPVT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ubxpvt assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define UBXPVT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ubxpvt assertion failed");

`endif

// ===== design/ubxpvt_pkg.sv =====
// Shared constants, types and the field layout table of the NAV-PVT frame parser.
// Used by the front parser, the command queue, the field emitter and the top level.
package ubxpvt_pkg;

    localparam int PAYLOAD_BYTES = 92;
    localparam int FIELD_COUNT   = 22;
    localparam int OQ_DEPTH      = 4;

    localparam logic [7:0] SYNC_FIRST    = 8'hB5;
    localparam logic [7:0] SYNC_SECOND   = 8'h62;
    localparam logic [7:0] PVT_CLASS     = 8'h01;
    localparam logic [7:0] PVT_ID        = 8'h07;
    localparam logic [7:0] THR_RESET     = 8'd3;
    localparam logic [6:0] FIX_BYTE_POS  = 7'd20;

    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    // Payload memory: two banks of 32 words (a payload fills 23), one byte lane per payload byte.
    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        logic [1:0] lane;
        logic [7:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic bank;
        logic ready;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_rel;

    typedef struct packed {
        logic [6:0] offset;
        logic [2:0] size;
        logic       is_signed;
    } t_field;

    typedef struct packed {
        logic [4:0]  index;
        logic [32:0] value;
        logic        ready;
        logic        last;
    } t_out;

    function automatic t_field field_desc(input logic [4:0] k);
        t_field d;
        unique case (k)
            5'd0:    d = '{7'd0,  SIZE_WORD, 1'b0};
            5'd1:    d = '{7'd4,  SIZE_HALF, 1'b0};
            5'd2:    d = '{7'd6,  SIZE_BYTE, 1'b0};
            5'd3:    d = '{7'd7,  SIZE_BYTE, 1'b0};
            5'd4:    d = '{7'd8,  SIZE_BYTE, 1'b0};
            5'd5:    d = '{7'd9,  SIZE_BYTE, 1'b0};
            5'd6:    d = '{7'd10, SIZE_BYTE, 1'b0};
            5'd7:    d = '{7'd11, SIZE_BYTE, 1'b0};
            5'd8:    d = '{7'd20, SIZE_BYTE, 1'b0};
            5'd9:    d = '{7'd23, SIZE_BYTE, 1'b0};
            5'd10:   d = '{7'd24, SIZE_WORD, 1'b1};
            5'd11:   d = '{7'd28, SIZE_WORD, 1'b1};
            5'd12:   d = '{7'd32, SIZE_WORD, 1'b1};
            5'd13:   d = '{7'd36, SIZE_WORD, 1'b1};
            5'd14:   d = '{7'd40, SIZE_WORD, 1'b0};
            5'd15:   d = '{7'd44, SIZE_WORD, 1'b0};
            5'd16:   d = '{7'd48, SIZE_WORD, 1'b1};
            5'd17:   d = '{7'd52, SIZE_WORD, 1'b1};
            5'd18:   d = '{7'd56, SIZE_WORD, 1'b1};
            5'd19:   d = '{7'd60, SIZE_WORD, 1'b1};
            5'd20:   d = '{7'd68, SIZE_WORD, 1'b0};
            5'd21:   d = '{7'd76, SIZE_HALF, 1'b0};
            default: d = '{7'd0,  SIZE_WORD, 1'b0};
        endcase
        return d;
    endfunction

endpackage

// ===== design/ubxpvt_front.sv =====
// Byte-level frame parser: sync hunt, header check, checksum and payload capture.
// Depends on ubxpvt_pkg; writes the payload memory held by ubxpvt_back.
module ubxpvt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [7:0]           i_rx_byte,
    input  logic [7:0]           i_fix_threshold,
    output ubxpvt_pkg::t_mem_wr  o_wr,
    output logic                 o_cmd_push,
    output ubxpvt_pkg::t_cmd     o_cmd,
    input  ubxpvt_pkg::t_rel     i_rel
);
    import ubxpvt_pkg::*;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } t_phase;

    t_phase     r_phase,    n_phase;
    logic [7:0] r_len_lo,   n_len_lo;
    logic [6:0] r_cnt,      n_cnt;
    logic [7:0] r_sum_a,    n_sum_a;
    logic [7:0] r_sum_b,    n_sum_b;
    logic [7:0] r_ck_a,     n_ck_a;
    logic [7:0] r_fix_byte, n_fix_byte;
    logic       r_ready,    n_ready;
    logic       r_wbank,    n_wbank;
    logic [1:0] r_busy,     n_busy;

    logic       accept;
    logic [7:0] add_a;
    logic [7:0] add_b;

    // A payload byte may only land in a bank the emitter has released.
    assign o_full = (r_phase == PH_PAYLOAD) && r_busy[r_wbank];
    assign accept = i_push && !o_full;
    assign add_a  = r_sum_a + i_rx_byte;
    assign add_b  = r_sum_b + add_a;

    always_comb begin
        n_phase    = r_phase;
        n_len_lo   = r_len_lo;
        n_cnt      = r_cnt;
        n_sum_a    = r_sum_a;
        n_sum_b    = r_sum_b;
        n_ck_a     = r_ck_a;
        n_fix_byte = r_fix_byte;
        n_ready    = r_ready;
        n_wbank    = r_wbank;
        n_busy     = r_busy;
        o_wr       = '{1'b0, {r_wbank, r_cnt[6:2]}, r_cnt[1:0], i_rx_byte};
        o_cmd_push = 1'b0;
        o_cmd      = '{r_wbank, r_ready | (r_fix_byte >= i_fix_threshold)};

        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end

        if (accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == SYNC_FIRST) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    if (i_rx_byte == SYNC_SECOND) begin
                        n_phase = PH_CLASS;
                    end else if (i_rx_byte == SYNC_FIRST) begin
                        n_phase = PH_SYNC2;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_CLASS: begin
                    n_sum_a = '0;
                    n_sum_b = '0;
                    if (i_rx_byte == PVT_CLASS) begin
                        n_sum_a = i_rx_byte;
                        n_sum_b = i_rx_byte;
                        n_phase = PH_ID;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_ID: begin
                    if (i_rx_byte == PVT_ID) begin
                        n_sum_a = add_a;
                        n_sum_b = add_b;
                        n_phase = PH_LEN_LO;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LEN_LO: begin
                    n_len_lo = i_rx_byte;
                    n_sum_a  = add_a;
                    n_sum_b  = add_b;
                    n_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    if ({i_rx_byte, r_len_lo} == 16'(PAYLOAD_BYTES)) begin
                        n_sum_a = add_a;
                        n_sum_b = add_b;
                        n_cnt   = '0;
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    o_wr.en = 1'b1;
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_cnt   = r_cnt + 7'd1;
                    if (r_cnt == FIX_BYTE_POS) begin
                        n_fix_byte = i_rx_byte;
                    end
                    if (r_cnt == 7'(PAYLOAD_BYTES - 1)) begin
                        n_phase = PH_CK_A;
                    end
                end
                PH_CK_A: begin
                    n_ck_a  = i_rx_byte;
                    n_phase = PH_CK_B;
                end
                PH_CK_B: begin
                    if (r_sum_a == r_ck_a && r_sum_b == i_rx_byte) begin
                        n_ready         = o_cmd.ready;
                        o_cmd_push      = 1'b1;
                        n_busy[r_wbank] = 1'b1;
                        n_wbank         = ~r_wbank;
                    end
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_len_lo   <= '0;
            r_cnt      <= '0;
            r_sum_a    <= '0;
            r_sum_b    <= '0;
            r_ck_a     <= '0;
            r_fix_byte <= '0;
            r_ready    <= 1'b0;
            r_wbank    <= 1'b0;
            r_busy     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_len_lo   <= n_len_lo;
            r_cnt      <= n_cnt;
            r_sum_a    <= n_sum_a;
            r_sum_b    <= n_sum_b;
            r_ck_a     <= n_ck_a;
            r_fix_byte <= n_fix_byte;
            r_ready    <= n_ready;
            r_wbank    <= n_wbank;
            r_busy     <= n_busy;
        end
    end

endmodule

// ===== design/ubxpvt_cmdq.sv =====
// Two-entry queue of decoded-frame commands between the parser and the emitter.
// Depends on ubxpvt_pkg for the command type.
module ubxpvt_cmdq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ubxpvt_pkg::t_cmd  i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output ubxpvt_pkg::t_cmd  o_data
);
    import ubxpvt_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       pop_ok;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];
    assign pop_ok  = i_pop && o_valid;

    // Depth never overflows: each entry owns one of the two payload banks.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop_ok);
        end
    end

endmodule

// ===== design/ubxpvt_back.sv =====
// Field emitter: payload memory, the result queue and one field read per cycle while that queue has room.
// Depends on ubxpvt_pkg and on the assertion macros header.
`include "ubx_nav_pvt_frame_parser_unit_assert.svh"

module ubxpvt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ubxpvt_pkg::t_mem_wr  i_wr,
    input  logic                 i_cmd_valid,
    input  ubxpvt_pkg::t_cmd     i_cmd,
    output logic                 o_cmd_pop,
    output ubxpvt_pkg::t_rel     o_rel,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [4:0]           o_field_index,
    output logic signed [32:0]   o_field_value,
    output logic                 o_fix_ready,
    output logic                 o_last_field
);
    import ubxpvt_pkg::*;

    logic [31:0] r_mem [64];

    logic       r_active;
    logic       r_bank;
    logic       r_ready;
    logic [4:0] r_k;

    logic        r_rd_vld;
    logic [31:0] r_rdata;
    logic [1:0]  r_rd_off;
    logic [2:0]  r_rd_size;
    logic        r_rd_signed;
    logic [4:0]  r_rd_k;
    logic        r_rd_ready;

    t_out       r_oq [OQ_DEPTH];
    logic [1:0] r_oq_wp;
    logic [1:0] r_oq_rp;
    logic [2:0] r_oq_cnt;

    t_field      desc;
    logic        issue;
    logic        pop_ok;
    logic [31:0] shifted;
    logic [31:0] raw;
    t_out        fmt;

    assign desc      = field_desc(r_k);
    // One read may be in flight, so reserve a queue slot for it.
    assign issue     = r_active && ((r_oq_cnt + 3'(r_rd_vld)) < 3'(OQ_DEPTH));
    assign o_cmd_pop = !r_active && i_cmd_valid;
    assign o_rel     = '{issue && (r_k == 5'(FIELD_COUNT - 1)), r_bank};
    assign pop_ok    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr][{i_wr.lane, 3'b000} +: 8] <= i_wr.data;
        end
        if (issue) begin
            r_rdata <= r_mem[{r_bank, desc.offset[6:2]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_off    <= desc.offset[1:0];
            r_rd_size   <= desc.size;
            r_rd_signed <= desc.is_signed;
            r_rd_k      <= r_k;
            r_rd_ready  <= r_ready;
        end
        if (o_cmd_pop) begin
            r_bank  <= i_cmd.bank;
            r_ready <= i_cmd.ready;
        end
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_k      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (o_cmd_pop) begin
                r_active <= 1'b1;
                r_k      <= '0;
            end else if (issue) begin
                if (r_k == 5'(FIELD_COUNT - 1)) begin
                    r_active <= 1'b0;
                end else begin
                    r_k <= r_k + 5'd1;
                end
            end
        end
    end

    assign shifted = r_rdata >> {r_rd_off, 3'b000};

    always_comb begin
        unique case (r_rd_size)
            SIZE_BYTE: raw = {24'd0, shifted[7:0]};
            SIZE_HALF: raw = {16'd0, shifted[15:0]};
            default:   raw = shifted;
        endcase
        fmt.index = r_rd_k;
        fmt.value = {r_rd_signed & raw[31], raw};
        fmt.ready = r_rd_ready;
        fmt.last  = (r_rd_k == 5'(FIELD_COUNT - 1));
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_oq[r_oq_wp] <= fmt;
        end
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_rd_vld) begin
                r_oq_wp <= r_oq_wp + 2'd1;
            end
            if (pop_ok) begin
                r_oq_rp <= r_oq_rp + 2'd1;
            end
            r_oq_cnt <= r_oq_cnt + 3'(r_rd_vld) - 3'(pop_ok);
        end
    end

    assign o_empty       = (r_oq_cnt == 3'd0);
    assign o_field_index = r_oq[r_oq_rp].index;
    assign o_field_value = $signed(r_oq[r_oq_rp].value);
    assign o_fix_ready   = r_oq[r_oq_rp].ready;
    assign o_last_field  = r_oq[r_oq_rp].last;

    `UBXPVT_ASSERT_IMPL(a_oq_room, r_rd_vld, r_oq_cnt < 3'(OQ_DEPTH))
    `UBXPVT_ASSERT_IMPL(a_last_idx, !o_empty && o_last_field, o_field_index == 5'(FIELD_COUNT - 1))
    `UBXPVT_ASSERT_NEXT(a_rel_idle, o_rel.valid, !r_active)

endmodule

// ===== design/ubx_nav_pvt_frame_parser_unit.sv =====
// Top level of the NAV-PVT frame parser: configuration register and the three parts.
// Depends on ubxpvt_pkg, ubxpvt_front, ubxpvt_cmdq and ubxpvt_back.
//
// The unit takes one receiver byte per clock on the push side while full is
// low. Once a frame's checksum matches, its 22 fields are produced one per
// clock while the result queue has room, from a 64 x 32-bit payload memory
// with one read port (two banks, one frame each) through a registered read.
// full rises only while payload bytes of a third frame arrive and both banks
// still hold frames whose fields have not all been read; results wait in a
// four-entry queue, so a stalled pop side holds back at most the parser's
// payload phase. Register 0 at address 0 holds the fix-type threshold
// (reset 3) for the sticky ready flag.
module ubx_nav_pvt_frame_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_rx_byte,
    input  logic               pop,
    output logic               empty,
    output logic [4:0]         o_field_index,
    output logic signed [32:0] o_field_value,
    output logic               o_fix_ready,
    output logic               o_last_field,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ubxpvt_pkg::*;

    logic [7:0] r_fix_threshold;
    logic       cfg_wr;
    logic       sel_thr;

    t_mem_wr wr;
    t_cmd    cmd_in;
    t_cmd    cmd_out;
    t_rel    rel;
    logic    cmd_push;
    logic    cmd_valid;
    logic    cmd_pop;

    assign pready  = 1'b1;
    assign sel_thr = !paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = sel_thr ? {24'd0, r_fix_threshold} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fix_threshold <= THR_RESET;
        end else if (cfg_wr && sel_thr) begin
            r_fix_threshold <= pwdata[7:0];
        end
    end

    ubxpvt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_rx_byte       (i_rx_byte),
        .i_fix_threshold (r_fix_threshold),
        .o_wr            (wr),
        .o_cmd_push      (cmd_push),
        .o_cmd           (cmd_in),
        .i_rel           (rel)
    );

    ubxpvt_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_data  (cmd_out)
    );

    ubxpvt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (wr),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd_out),
        .o_cmd_pop     (cmd_pop),
        .o_rel         (rel),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_field_index (o_field_index),
        .o_field_value (o_field_value),
        .o_fix_ready   (o_fix_ready),
        .o_last_field  (o_last_field)
    );

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the NAV-PVT frame parser unit: byte stream in, decoded fields out.
// Depends on ubxpvt_pkg and ubx_nav_pvt_frame_parser_unit; it predicts each field itself.
`timescale 1ns / 1ps

module testbench;
    import ubxpvt_pkg::*;

    localparam logic [2:0] ADDR_FIX_THRESHOLD = 3'd0;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_BYTES = 160;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [3:0] {
        PH_HUNT, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CK_A, PH_CK_B
    } parse_phase_e;

    // Header defects are listed in header byte order so that the offset from
    // DEF_SYNC1 is the position of the corrupted byte.
    typedef enum int {
        DEF_NONE, DEF_SYNC1, DEF_SYNC2, DEF_CLASS, DEF_ID, DEF_LEN_LO, DEF_LEN_HI,
        DEF_CK_A, DEF_CK_B
    } frame_defect_e;

    typedef struct packed {
        logic [4:0]  index;
        logic [32:0] value;
        logic        ready;
        logic        last;
    } decoded_field_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [7:0]         i_rx_byte;
    logic               pop = 1'b0;
    logic               empty;
    logic [4:0]         o_field_index;
    logic signed [32:0] o_field_value;
    logic               o_fix_ready;
    logic               o_last_field;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor state.
    parse_phase_e parse_phase;
    logic [7:0]   len_lo_seen;
    int           payload_pos;
    logic [7:0]   run_sum_a;
    logic [7:0]   run_sum_b;
    logic [7:0]   rx_check_a;
    logic [7:0]   rx_payload [PAYLOAD_BYTES];
    logic         fix_seen;
    logic [7:0]   fix_threshold;

    decoded_field_t expected_fields [$];
    decoded_field_t want;

    logic [7:0] tx_payload [PAYLOAD_BYTES];
    bit         idling_on = 1'b1;
    int         pop_hold = 0;
    int         cycle_count = 0;
    int         bytes_sent = 0;
    int         frames_decoded = 0;
    int         fields_checked = 0;
    int         threshold_writes = 0;
    int         field_errors = 0;

    ubx_nav_pvt_frame_parser_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_rx_byte    (i_rx_byte),
        .pop          (pop),
        .empty        (empty),
        .o_field_index(o_field_index),
        .o_field_value(o_field_value),
        .o_fix_ready  (o_fix_ready),
        .o_last_field (o_last_field),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        if (field_errors < REPORT_LIMIT) begin
            $display("[%0t] ERROR: %s", $time, msg);
        end
        field_errors++;
    endtask

    task automatic fold_into_checksum(input logic [7:0] b);
        run_sum_a = run_sum_a + b;
        run_sum_b = run_sum_b + run_sum_a;
    endtask

    // Advances the frame parse by one accepted byte and queues the fields of
    // a frame whose checksum matches.
    task automatic parse_accepted_byte(input logic [7:0] b);
        decoded_field_t f;
        logic [31:0]    word;
        int             k;
        int             i;
        int             ofs;
        int             len;
        case (parse_phase)
            PH_HUNT: begin
                if (b == SYNC_FIRST) parse_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (b == SYNC_SECOND) parse_phase = PH_CLASS;
                else if (b != SYNC_FIRST) parse_phase = PH_HUNT;
            end
            PH_CLASS: begin
                run_sum_a = 8'h00;
                run_sum_b = 8'h00;
                if (b == PVT_CLASS) begin
                    fold_into_checksum(b);
                    parse_phase = PH_ID;
                end else begin
                    parse_phase = PH_HUNT;
                end
            end
            PH_ID: begin
                if (b == PVT_ID) begin
                    fold_into_checksum(b);
                    parse_phase = PH_LEN_LO;
                end else begin
                    parse_phase = PH_HUNT;
                end
            end
            PH_LEN_LO: begin
                len_lo_seen = b;
                fold_into_checksum(b);
                parse_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                if ({b, len_lo_seen} == 16'(PAYLOAD_BYTES)) begin
                    fold_into_checksum(b);
                    payload_pos = 0;
                    parse_phase = PH_PAYLOAD;
                end else begin
                    parse_phase = PH_HUNT;
                end
            end
            PH_PAYLOAD: begin
                rx_payload[payload_pos] = b;
                fold_into_checksum(b);
                payload_pos++;
                if (payload_pos >= PAYLOAD_BYTES) parse_phase = PH_CK_A;
            end
            PH_CK_A: begin
                rx_check_a = b;
                parse_phase = PH_CK_B;
            end
            PH_CK_B: begin
                if (run_sum_a == rx_check_a && run_sum_b == b) begin
                    if (rx_payload[FIX_BYTE_POS] >= fix_threshold) fix_seen = 1'b1;
                    for (k = 0; k < FIELD_COUNT; k++) begin
                        case (k)
                            0: begin
                                ofs = 0;
                                len = 4;
                            end
                            1: begin
                                ofs = 4;
                                len = 2;
                            end
                            8: begin
                                ofs = 20;
                                len = 1;
                            end
                            9: begin
                                ofs = 23;
                                len = 1;
                            end
                            20: begin
                                ofs = 68;
                                len = 4;
                            end
                            21: begin
                                ofs = 76;
                                len = 2;
                            end
                            default: begin
                                // Date and time bytes, then the run of 32-bit fields.
                                if (k < 8) begin
                                    ofs = k + 4;
                                    len = 1;
                                end else begin
                                    ofs = 24 + 4 * (k - 10);
                                    len = 4;
                                end
                            end
                        endcase
                        word = 32'h0;
                        for (i = 0; i < len; i++) word[8*i +: 8] = rx_payload[ofs + i];
                        f.index = 5'(k);
                        f.value = {((k >= 10 && k <= 13) || (k >= 16 && k <= 19)) && word[31],
                                   word};
                        f.ready = fix_seen;
                        f.last = (k == FIELD_COUNT - 1);
                        expected_fields.push_back(f);
                    end
                    frames_decoded++;
                end
                parse_phase = PH_HUNT;
            end
            default: parse_phase = PH_HUNT;
        endcase
    endtask

    // One received byte is one pushed word.
    task automatic send_rx_byte(input logic [7:0] b);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 11)) begin
                i_rx_byte = 8'($urandom);
                @(negedge i_clk);
            end
        end
        push = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (full);
        parse_accepted_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Sends a frame built from tx_payload. A short payload ends the frame
    // before its check bytes.
    task automatic send_pvt_frame(input frame_defect_e defect, input int payload_len);
        logic [7:0] hdr [6];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        int         i;
        hdr[0] = SYNC_FIRST;
        hdr[1] = SYNC_SECOND;
        hdr[2] = PVT_CLASS;
        hdr[3] = PVT_ID;
        hdr[4] = 8'(PAYLOAD_BYTES);
        hdr[5] = 8'h00;
        ck_a = 8'h00;
        ck_b = 8'h00;
        for (i = 2; i < 6; i++) begin
            ck_a = ck_a + hdr[i];
            ck_b = ck_b + ck_a;
        end
        for (i = 0; i < PAYLOAD_BYTES; i++) begin
            ck_a = ck_a + tx_payload[i];
            ck_b = ck_b + ck_a;
        end
        if (defect >= DEF_SYNC1 && defect <= DEF_LEN_HI) begin
            i = int'(defect) - int'(DEF_SYNC1);
            hdr[i] = hdr[i] ^ 8'($urandom_range(1, 255));
        end
        if (defect == DEF_CK_A) ck_a = ck_a ^ 8'($urandom_range(1, 255));
        if (defect == DEF_CK_B) ck_b = ck_b ^ 8'($urandom_range(1, 255));
        for (i = 0; i < 6; i++) send_rx_byte(hdr[i]);
        for (i = 0; i < payload_len; i++) send_rx_byte(tx_payload[i]);
        if (payload_len == PAYLOAD_BYTES) begin
            send_rx_byte(ck_a);
            send_rx_byte(ck_b);
        end
    endtask

    task automatic fill_payload_random();
        int i;
        for (i = 0; i < PAYLOAD_BYTES; i++) tx_payload[i] = 8'($urandom);
        if ($urandom_range(0, 1) == 1) tx_payload[FIX_BYTE_POS] = 8'($urandom_range(0, 5));
    endtask

    // Top byte of every aligned 32-bit group gets msb, the others rest.
    task automatic fill_payload_pattern(input logic [7:0] msb, input logic [7:0] rest);
        int i;
        for (i = 0; i < PAYLOAD_BYTES; i++) tx_payload[i] = (i % 4 == 3) ? msb : rest;
    endtask

    task automatic write_fix_threshold(input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_FIX_THRESHOLD;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        fix_threshold = value[7:0];
        threshold_writes++;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Holds the sender until every queued field has been popped, then lets
    // the parser settle.
    task automatic wait_drained();
        push = 1'b0;
        while (expected_fields.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_fix_threshold();
        // Reset threshold is 3, so fix type 2 must leave the flag clear.
        fill_payload_random();
        tx_payload[FIX_BYTE_POS] = 8'd2;
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
        wait_drained();
        write_fix_threshold({24'($urandom), 8'hFF});
        fill_payload_random();
        tx_payload[FIX_BYTE_POS] = 8'hFE;
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
        fill_payload_random();
        tx_payload[FIX_BYTE_POS] = 8'hFF;
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
        wait_drained();
        write_fix_threshold({24'($urandom), 8'h00});
        fill_payload_random();
        tx_payload[FIX_BYTE_POS] = 8'h00;
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
    endtask

    task automatic test_field_extremes();
        fill_payload_pattern(8'h00, 8'h00);
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
        fill_payload_pattern(8'hFF, 8'hFF);
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
        fill_payload_pattern(8'h80, 8'h00);
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
        fill_payload_pattern(8'h7F, 8'hFF);
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
    endtask

    task automatic test_header_recovery();
        int d;
        fill_payload_random();
        // Repeated first sync bytes stay in the sync phase.
        send_rx_byte(SYNC_FIRST);
        send_rx_byte(SYNC_FIRST);
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
        send_rx_byte(SYNC_FIRST);
        send_rx_byte(8'h00);
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
        // A sync byte in the class slot is dropped, not taken as a new sync.
        send_rx_byte(SYNC_FIRST);
        send_rx_byte(SYNC_SECOND);
        send_rx_byte(SYNC_FIRST);
        send_rx_byte(SYNC_SECOND);
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
        for (d = DEF_SYNC1; d <= DEF_CK_B; d++) begin
            fill_payload_random();
            send_pvt_frame(frame_defect_e'(d), PAYLOAD_BYTES);
            send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
        end
        // A cut frame swallows the start of the next one as payload.
        send_pvt_frame(DEF_NONE, 40);
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
        send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
    endtask

    task automatic test_random_stream();
        int kind;
        int first_byte;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            fill_payload_random();
            if (kind < 65) begin
                send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
            end else if (kind < 75) begin
                send_pvt_frame(frame_defect_e'($urandom_range(DEF_SYNC1, DEF_LEN_HI)),
                               PAYLOAD_BYTES);
            end else if (kind < 83) begin
                send_pvt_frame(frame_defect_e'($urandom_range(DEF_CK_A, DEF_CK_B)),
                               PAYLOAD_BYTES);
            end else if (kind < 90) begin
                send_pvt_frame(DEF_NONE, $urandom_range(0, PAYLOAD_BYTES - 1));
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_rx_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
                end
            end
        end
    endtask

    task automatic test_quiet_tail();
        repeat (2) begin
            fill_payload_random();
            send_pvt_frame(DEF_NONE, PAYLOAD_BYTES);
        end
    endtask

    always @(negedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            pop_hold <= $urandom_range(0, 10);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_fields.size() == 0) begin
                note_failure($sformatf("unexpected field idx=%0d value=%h ready=%b last=%b",
                                       o_field_index, o_field_value, o_fix_ready,
                                       o_last_field));
            end else begin
                want = expected_fields.pop_front();
                fields_checked++;
                if (o_field_index !== want.index || o_field_value !== want.value ||
                    o_fix_ready !== want.ready || o_last_field !== want.last) begin
                    note_failure({
                        $sformatf("mismatch: expected idx=%0d value=%h ready=%b last=%b",
                                  want.index, want.value, want.ready, want.last),
                        $sformatf(", got idx=%0d value=%h ready=%b last=%b",
                                  o_field_index, o_field_value, o_fix_ready, o_last_field)});
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[%0t] timeout after %0d cycles", $time, cycle_count);
        $display("ubx_nav_pvt_frame_parser_unit verification failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_rx_byte = 8'h00;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_FIX_THRESHOLD;
        pwdata = 32'h0;
        parse_phase = PH_HUNT;
        len_lo_seen = 8'h00;
        payload_pos = 0;
        run_sum_a = 8'h00;
        run_sum_b = 8'h00;
        rx_check_a = 8'h00;
        fix_seen = 1'b0;
        fix_threshold = THR_RESET;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_fix_threshold();
        wait_drained();
        test_field_extremes();
        wait_drained();
        test_header_recovery();
        wait_drained();
        test_random_stream();
        wait_drained();
        write_fix_threshold($urandom);
        idling_on = 1'b0;
        test_quiet_tail();
        wait_drained();

        if (expected_fields.size() != 0) begin
            note_failure($sformatf("%0d fields never arrived", expected_fields.size()));
        end
        $display("Sent %0d bytes with header, checksum and truncation faults mixed in.",
                 bytes_sent);
        $display("Decoded %0d frames, checked %0d fields, %0d threshold writes, %0d errors.",
                 frames_decoded, fields_checked, threshold_writes, field_errors);
        if (field_errors == 0) begin
            $display("ubx_nav_pvt_frame_parser_unit verification clean");
        end else begin
            $display("ubx_nav_pvt_frame_parser_unit verification failed");
        end
        $finish;
    end

endmodule
